// File: src/rc_channel_frame_parser_assert.svh
// assertion macros used by the frame parser unpacker module
`ifndef RC_CHANNEL_FRAME_PARSER_ASSERT_SVH
`define RC_CHANNEL_FRAME_PARSER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RCFP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcfp assertion failed");

// next-cycle implication, checked out of reset
`define RCFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcfp assertion failed");

`endif

// File: src/rcfp_pkg.sv
// package: constants, types and crc helper of the rc channel frame parser
package rcfp_pkg;

    localparam int NUM_CHANNELS  = 16;
    localparam int CH_BITS       = 11;
    localparam int PAYLOAD_BYTES = (NUM_CHANNELS * CH_BITS + 7) / 8;
    localparam int ADDR_W        = $clog2(PAYLOAD_BYTES);
    localparam int COUNT_W       = 5;
    localparam int CH_IDX_W      = 4;
    localparam int ACC_W         = CH_BITS + 7;
    localparam int NBITS_W       = $clog2(ACC_W + 1);
    localparam int CFG_IDX_W     = 2;

    localparam logic [7:0] CRC_POLY = 8'hD5;
    localparam logic [7:0] ADDRESS_RESET = 8'hC8;
    localparam logic [7:0] LENGTH_RESET  = 8'd24;
    localparam logic [7:0] TYPE_RESET    = 8'h16;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_LEN,
        ST_TYPE,
        ST_PAYLOAD,
        ST_CRC,
        ST_UNPACK
    } t_parse_state;

    typedef enum logic [1:0] {
        UNP_IDLE,
        UNP_READ,
        UNP_MERGE,
        UNP_EMIT
    } t_unp_state;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ADDRESS = 2'd0,
        CFG_LENGTH  = 2'd1,
        CFG_TYPE    = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_ram_wr;

    typedef struct packed {
        logic start;
        logic crc_ok;
    } t_unp_ctrl;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] v;
        v = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

// File: src/rcfp_payload_ram.sv
// payload byte store: one write port, one registered read port
module rcfp_payload_ram
    import rcfp_pkg::*;
(
    input  logic              i_clk,
    input  t_ram_wr           i_wr,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data
);

    logic [7:0] mem [PAYLOAD_BYTES];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/rcfp_unpacker.sv
// channel unpacker: reads payload bytes, slices 11-bit channels, output register
module rcfp_unpacker
    import rcfp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_unp_ctrl           i_ctrl,
    output logic                o_busy,
    output logic                o_rd_en,
    output logic [ADDR_W-1:0]   o_rd_addr,
    input  logic [7:0]          i_rd_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [CH_IDX_W-1:0] o_channel_index,
    output logic [CH_BITS-1:0]  o_channel_value,
    output logic                o_crc_ok,
    output logic                o_last
);

`include "rc_channel_frame_parser_assert.svh"

    localparam logic [CH_IDX_W-1:0] LAST_CH = CH_IDX_W'(NUM_CHANNELS - 1);
    localparam logic [NBITS_W-1:0]  CH_BITS_N = NBITS_W'(CH_BITS);

    t_unp_state           r_state, n_state;
    logic [ACC_W-1:0]     r_acc, n_acc;
    logic [NBITS_W-1:0]   r_nbits, n_nbits;
    logic [COUNT_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CH_IDX_W-1:0]  r_ch_idx, n_ch_idx;
    logic                 r_crc_ok, n_crc_ok;
    logic                 r_out_valid, n_out_valid;
    logic [CH_IDX_W-1:0]  r_out_index, n_out_index;
    logic [CH_BITS-1:0]   r_out_value, n_out_value;
    logic                 r_out_crc_ok, n_out_crc_ok;
    logic                 r_out_last, n_out_last;
    logic                 slot_free;
    logic [NBITS_W-1:0]   nbits_after_emit;

    assign slot_free        = !r_out_valid || !i_out_stall;
    assign nbits_after_emit = r_nbits - CH_BITS_N;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= UNP_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc        <= n_acc;
        r_nbits      <= n_nbits;
        r_rd_ptr     <= n_rd_ptr;
        r_ch_idx     <= n_ch_idx;
        r_crc_ok     <= n_crc_ok;
        r_out_index  <= n_out_index;
        r_out_value  <= n_out_value;
        r_out_crc_ok <= n_out_crc_ok;
        r_out_last   <= n_out_last;
    end

    always_comb begin
        n_state      = r_state;
        n_acc        = r_acc;
        n_nbits      = r_nbits;
        n_rd_ptr     = r_rd_ptr;
        n_ch_idx     = r_ch_idx;
        n_crc_ok     = r_crc_ok;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_index  = r_out_index;
        n_out_value  = r_out_value;
        n_out_crc_ok = r_out_crc_ok;
        n_out_last   = r_out_last;
        o_rd_en      = 1'b0;
        unique case (r_state)
            UNP_IDLE: begin
                if (i_ctrl.start) begin
                    n_acc    = '0;
                    n_nbits  = '0;
                    n_rd_ptr = '0;
                    n_ch_idx = '0;
                    n_crc_ok = i_ctrl.crc_ok;
                    n_state  = UNP_READ;
                end
            end
            UNP_READ: begin
                o_rd_en  = 1'b1;
                n_rd_ptr = r_rd_ptr + COUNT_W'(1);
                n_state  = UNP_MERGE;
            end
            UNP_MERGE: begin
                n_acc   = r_acc | (ACC_W'(i_rd_data) << r_nbits);
                n_nbits = r_nbits + NBITS_W'(8);
                if (n_nbits >= CH_BITS_N) begin
                    n_state = UNP_EMIT;
                end else begin
                    n_state = UNP_READ;
                end
            end
            UNP_EMIT: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_index  = r_ch_idx;
                    n_out_value  = r_acc[CH_BITS-1:0];
                    n_out_crc_ok = r_crc_ok;
                    n_out_last   = (r_ch_idx == LAST_CH);
                    n_acc        = r_acc >> CH_BITS;
                    n_nbits      = nbits_after_emit;
                    n_ch_idx     = r_ch_idx + CH_IDX_W'(1);
                    priority if (r_ch_idx == LAST_CH) begin
                        n_state = UNP_IDLE;
                    end else if (nbits_after_emit >= CH_BITS_N) begin
                        n_state = UNP_EMIT;
                    end else begin
                        n_state = UNP_READ;
                    end
                end
            end
            default: n_state = UNP_IDLE;
        endcase
    end

    assign o_busy          = (r_state != UNP_IDLE);
    assign o_rd_addr       = r_rd_ptr[ADDR_W-1:0];
    assign o_out_valid     = r_out_valid;
    assign o_channel_index = r_out_index;
    assign o_channel_value = r_out_value;
    assign o_crc_ok        = r_out_crc_ok;
    assign o_last          = r_out_last;

    `RCFP_ASSERT_NOW(a_emit_has_bits, i_clk, i_rst_n, r_state == UNP_EMIT, r_nbits >= CH_BITS_N)
    `RCFP_ASSERT_NOW(a_read_in_range, i_clk, i_rst_n, o_rd_en, r_rd_ptr < COUNT_W'(PAYLOAD_BYTES))
    `RCFP_ASSERT_NOW(a_frame_consumed, i_clk, i_rst_n, $fell(o_busy), r_nbits < NBITS_W'(8))

endmodule

// File: src/rc_channel_frame_parser.sv
// rc channel frame parser top level: byte framing, crc and unpack control
//
// Input channel (i_in_valid / o_in_stall / i_rx_byte) takes one received byte
// per request. The parser hunts for the address byte, checks length and type
// against the configured values and stores the payload bytes while updating a
// crc-8 (poly 0xd5). Bytes are taken one per cycle while framing.
// On the crc byte the payload ram is read back one byte at a time and
// the output channel (o_out_valid / i_out_stall) delivers NUM_CHANNELS
// requests, channel index 0 first, o_last on the final one. The first request
// is valid once two payload bytes have been read and merged. Input is stalled
// while the frame is unpacked, also while the output is stalled; the frame is
// read back through the single ram read port.
// The output register lets the receiver stall at any time; a held request
// does not change. Config writes (i_cfg_valid / o_cfg_ready) go to address,
// length or type match registers, other indexes are ignored; always ready.
// Synchronous reset restores match values 0xc8, 24, 0x16 and the hunt.
module rc_channel_frame_parser
    import rcfp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [CH_IDX_W-1:0]  o_channel_index,
    output logic [CH_BITS-1:0]   o_channel_value,
    output logic                 o_crc_ok,
    output logic                 o_last,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    t_parse_state       r_state, n_state;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [7:0]         r_crc, n_crc;
    logic [7:0]         r_address_match, r_length_match, r_type_match;
    logic               in_accept;
    t_ram_wr            ram_wr;
    t_unp_ctrl          unp_ctrl;
    logic               unp_busy;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [7:0]         rd_data;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state == ST_UNPACK);
    assign in_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_address_match <= ADDRESS_RESET;
            r_length_match  <= LENGTH_RESET;
            r_type_match    <= TYPE_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ADDRESS: r_address_match <= i_cfg_data;
                CFG_LENGTH:  r_length_match  <= i_cfg_data;
                CFG_TYPE:    r_type_match    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
            r_count <= '0;
            r_crc   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_crc   <= n_crc;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_count         = r_count;
        n_crc           = r_crc;
        ram_wr.en       = 1'b0;
        ram_wr.addr     = r_count[ADDR_W-1:0];
        ram_wr.data     = i_rx_byte;
        unp_ctrl.start  = 1'b0;
        unp_ctrl.crc_ok = (i_rx_byte == r_crc);
        unique case (r_state)
            ST_HUNT: begin
                if (in_accept) begin
                    n_count = '0;
                    n_state = (i_rx_byte == r_address_match) ? ST_LEN : ST_HUNT;
                end
            end
            ST_LEN: begin
                if (in_accept) begin
                    n_count = '0;
                    n_state = (i_rx_byte == r_length_match) ? ST_TYPE : ST_HUNT;
                end
            end
            ST_TYPE: begin
                if (in_accept) begin
                    n_count = '0;
                    if (i_rx_byte == r_type_match) begin
                        n_crc   = crc8_update(8'h00, i_rx_byte);
                        n_state = ST_PAYLOAD;
                    end else begin
                        n_state = ST_HUNT;
                    end
                end
            end
            ST_PAYLOAD: begin
                if (in_accept) begin
                    ram_wr.en = 1'b1;
                    n_crc     = crc8_update(r_crc, i_rx_byte);
                    n_count   = r_count + COUNT_W'(1);
                    if (n_count >= COUNT_W'(PAYLOAD_BYTES)) begin
                        n_state = ST_CRC;
                    end
                end
            end
            ST_CRC: begin
                if (in_accept) begin
                    unp_ctrl.start = 1'b1;
                    n_count        = '0;
                    n_state        = ST_UNPACK;
                end
            end
            ST_UNPACK: begin
                if (!unp_busy) begin
                    n_state = ST_HUNT;
                end
            end
            default: n_state = ST_HUNT;
        endcase
    end

    rcfp_payload_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (ram_wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    rcfp_unpacker u_unpacker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (unp_ctrl),
        .o_busy          (unp_busy),
        .o_rd_en         (rd_en),
        .o_rd_addr       (rd_addr),
        .i_rd_data       (rd_data),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_crc_ok        (o_crc_ok),
        .o_last          (o_last)
    );

endmodule
